// File: src/sset_pkg.sv
// Shared constants and controller/datapath handshake types for the span extent table.
package sset_pkg;

  localparam int unsigned LINES_DEF  = 1024;
  localparam int unsigned ATTRS_DEF  = 4;
  localparam int unsigned ATTR_PORTS = 4;
  localparam int unsigned LINE_W     = 10;
  localparam int unsigned X_W        = 16;
  localparam int unsigned ATTR_W     = 32;
  localparam int unsigned LCNT_W     = 11;
  localparam int unsigned MAXX_W     = 15;
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned DATA_W     = 32;

  localparam logic [X_W-1:0]    EMPTY_X        = '1;
  localparam logic [LCNT_W-1:0] LINE_COUNT_RST = 11'd1024;
  localparam logic [MAXX_W-1:0] MAX_X_RST      = 15'd1023;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_DRAIN  = 1'b1
  } act_e;

  typedef enum logic {
    REG_LINE_COUNT = 1'b0,
    REG_MAX_X      = 1'b1
  } reg_e;

  typedef struct packed {
    logic accept;  // take the input item and read its line
    logic clr_wr;  // write one entry of the clearing pass
    logic exec;    // finish the item: write back and, on a drain, load the result
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_drain;
    logic out_free;
  } sts_t;

endpackage

// File: src/sset_ctrl.sv
// Controller state machine: clearing pass, item accept and item completion.
module sset_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sset_pkg::sts_t sts_i,
  output sset_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o.accept = 1'b0;
    cmd_o.clr_wr = 1'b0;
    cmd_o.exec   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // A drain waits until the output register can take its result.
        if (!sts_i.is_drain || sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  a_cmd_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.accept, cmd_o.clr_wr, cmd_o.exec}))
    else $error("controller issued two commands at once");

  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == ST_EXEC))
    else $error("accepted item did not move to execution");

endmodule

// File: src/sset_dp.sv
// Datapath: line memory, read-modify-write of one line, clearing pass and result register.
module sset_dp #(
  parameter int unsigned LINES = sset_pkg::LINES_DEF,
  parameter int unsigned ATTRS = sset_pkg::ATTRS_DEF
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  sset_pkg::cmd_t                                   cmd_i,
  output sset_pkg::sts_t                                   sts_o,
  input  logic [sset_pkg::LCNT_W-1:0]                      line_count_i,
  input  logic [sset_pkg::MAXX_W-1:0]                      max_x_i,
  input  logic                                             action_i,
  input  logic [sset_pkg::LINE_W-1:0]                      line_i,
  input  logic signed [sset_pkg::X_W-1:0]                  x_i,
  input  logic [sset_pkg::ATTR_PORTS-1:0][sset_pkg::ATTR_W-1:0] attr_i,
  output logic                                             out_valid_o,
  input  logic                                             out_stall_i,
  output logic                                             drawn_o,
  output logic [sset_pkg::LINE_W-1:0]                      span_line_o,
  output logic signed [sset_pkg::X_W-1:0]                  left_x_o,
  output logic signed [sset_pkg::X_W-1:0]                  right_x_o,
  output logic [sset_pkg::ATTR_PORTS-1:0][sset_pkg::ATTR_W-1:0] left_a_o,
  output logic [sset_pkg::ATTR_PORTS-1:0][sset_pkg::ATTR_W-1:0] right_a_o
);

  localparam int unsigned IDX_W  = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned OUT_AW = sset_pkg::ATTR_PORTS * sset_pkg::ATTR_W;

  typedef struct packed {
    logic [sset_pkg::X_W-1:0]                le;
    logic [sset_pkg::X_W-1:0]                re;
    logic [ATTRS-1:0][sset_pkg::ATTR_W-1:0]  la;
    logic [ATTRS-1:0][sset_pkg::ATTR_W-1:0]  ra;
  } ent_t;

  localparam ent_t ENT_EMPTY = '{le: sset_pkg::EMPTY_X, re: sset_pkg::EMPTY_X,
                                 la: '0, ra: '0};

  ent_t mem [LINES];
  ent_t rd_q;
  ent_t upd;
  ent_t mem_wd;
  logic [IDX_W-1:0] mem_wa;
  logic             mem_we;

  logic [IDX_W-1:0] clr_q;

  sset_pkg::act_e                          action_q;
  logic [sset_pkg::LINE_W-1:0]             line_q;
  logic signed [sset_pkg::X_W-1:0]         x_q;
  logic [ATTRS-1:0][sset_pkg::ATTR_W-1:0]  attr_q;

  logic in_rng, ins_ok, empty, wr_ok, off, out_load;
  logic signed [sset_pkg::X_W-1:0] l_x, r_x;
  logic signed [sset_pkg::MAXX_W+1:0] mx;

  logic                                out_valid_q;
  logic                                drawn_q;
  logic [sset_pkg::LINE_W-1:0]         line_oq;
  logic signed [sset_pkg::X_W-1:0]     lx_q, rx_q;
  logic [OUT_AW-1:0]                   la_q, ra_q;

  // Item registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= sset_pkg::act_e'(action_i);
      line_q   <= line_i;
      x_q      <= x_i;
      attr_q   <= attr_i[ATTRS-1:0];
    end
  end

  // Clearing pass counter, one entry per cycle after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  assign in_rng = (32'(line_q) < LINES);
  assign ins_ok = in_rng && ({1'b0, line_q} < line_count_i);
  assign empty  = (rd_q.le == sset_pkg::EMPTY_X) && (rd_q.re == sset_pkg::EMPTY_X);
  assign l_x    = $signed(rd_q.le);
  assign r_x    = $signed(rd_q.re);

  always_comb begin
    upd = rd_q;
    if (action_q == sset_pkg::ACT_INSERT) begin
      if (empty) begin
        upd.le = x_q;
        upd.re = x_q;
        upd.la = attr_q;
        upd.ra = attr_q;
      end else if (l_x > x_q) begin
        upd.le = x_q;
        upd.la = attr_q;
      end else if (r_x < x_q) begin
        upd.re = x_q;
        upd.ra = attr_q;
      end
    end else begin
      upd = ENT_EMPTY;
    end
  end

  assign wr_ok  = (action_q == sset_pkg::ACT_INSERT) ? ins_ok : in_rng;
  assign mem_we = cmd_i.clr_wr || (cmd_i.exec && wr_ok);
  assign mem_wa = cmd_i.clr_wr ? clr_q : IDX_W'(line_q);
  assign mem_wd = cmd_i.clr_wr ? ENT_EMPTY : upd;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.accept) begin
      rd_q <= mem[IDX_W'(line_i)];
    end
  end

  // Visibility test, signed against the zero-extended right screen edge.
  assign mx  = $signed({2'b00, max_x_i});
  assign off = ((l_x < 0) && (r_x < 0)) || ((l_x > mx) && (r_x > mx));

  assign out_load = cmd_i.exec && (action_q == sset_pkg::ACT_DRAIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      line_oq <= line_q;
      if (in_rng) begin
        drawn_q <= !off;
        lx_q    <= l_x;
        rx_q    <= r_x;
        la_q    <= OUT_AW'(rd_q.la);
        ra_q    <= OUT_AW'(rd_q.ra);
      end else begin
        drawn_q <= 1'b0;
        lx_q    <= $signed(sset_pkg::EMPTY_X);
        rx_q    <= $signed(sset_pkg::EMPTY_X);
        la_q    <= '0;
        ra_q    <= '0;
      end
    end
  end

  assign sts_o.clr_last = (clr_q == IDX_W'(LINES - 1));
  assign sts_o.is_drain = (action_q == sset_pkg::ACT_DRAIN);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign drawn_o     = drawn_q;
  assign span_line_o = line_oq;
  assign left_x_o    = lx_q;
  assign right_x_o   = rx_q;
  assign left_a_o    = la_q;
  assign right_a_o   = ra_q;

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a result not yet taken");

  a_load_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("loaded result not presented");

  a_drawn_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && drawn_q) |-> !(lx_q == -1 && rx_q == -1))
    else $error("empty line reported as drawn");

  a_no_write_oor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && mem_we) |-> in_rng)
    else $error("write to a line outside the table");

endmodule

// File: src/scanline_span_extent_table.sv
// Top level of the scanline span extent table: register port, controller and datapath.
//
//  port group   direction  handshake            payload
//  item in      in         in_valid_i/in_stall_o action_i line_i x_i attr0_i..attr3_i
//  result out   out        out_valid_o/out_stall_i drawn_o span_line_o left_x_o right_x_o
//                                                left_a0_o..left_a3_o right_a0_o..right_a3_o
//  registers    in/out     psel penable pwrite  paddr pwdata prdata pready
//
// Each item is handled in an accept step that reads its line from the line memory,
// then an execute step that updates and writes the line back (or, on a drain,
// loads the result register). After reset a clearing pass writes every line
// empty, with in_stall_o high. A drain waits in its execute step while the
// result register holds a result that is stalled; inserts proceed regardless.
module scanline_span_extent_table #(
  parameter int unsigned LINES = sset_pkg::LINES_DEF,
  parameter int unsigned ATTRS = sset_pkg::ATTRS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sset_pkg::ADDR_W-1:0]        paddr,
  input  logic [sset_pkg::DATA_W-1:0]        pwdata,
  output logic [sset_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               action_i,
  input  logic [sset_pkg::LINE_W-1:0]        line_i,
  input  logic signed [sset_pkg::X_W-1:0]    x_i,
  input  logic [sset_pkg::ATTR_W-1:0]        attr0_i,
  input  logic [sset_pkg::ATTR_W-1:0]        attr1_i,
  input  logic [sset_pkg::ATTR_W-1:0]        attr2_i,
  input  logic [sset_pkg::ATTR_W-1:0]        attr3_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               drawn_o,
  output logic [sset_pkg::LINE_W-1:0]        span_line_o,
  output logic signed [sset_pkg::X_W-1:0]    left_x_o,
  output logic signed [sset_pkg::X_W-1:0]    right_x_o,
  output logic [sset_pkg::ATTR_W-1:0]        left_a0_o,
  output logic [sset_pkg::ATTR_W-1:0]        left_a1_o,
  output logic [sset_pkg::ATTR_W-1:0]        left_a2_o,
  output logic [sset_pkg::ATTR_W-1:0]        left_a3_o,
  output logic [sset_pkg::ATTR_W-1:0]        right_a0_o,
  output logic [sset_pkg::ATTR_W-1:0]        right_a1_o,
  output logic [sset_pkg::ATTR_W-1:0]        right_a2_o,
  output logic [sset_pkg::ATTR_W-1:0]        right_a3_o
);

  logic [sset_pkg::LCNT_W-1:0] line_count_q;
  logic [sset_pkg::MAXX_W-1:0] max_x_q;
  logic                        cfg_wr;
  sset_pkg::reg_e              reg_sel;

  sset_pkg::cmd_t cmd;
  sset_pkg::sts_t sts;

  logic [sset_pkg::ATTR_PORTS-1:0][sset_pkg::ATTR_W-1:0] attr, left_a, right_a;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = sset_pkg::reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q <= sset_pkg::LINE_COUNT_RST;
      max_x_q      <= sset_pkg::MAX_X_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        sset_pkg::REG_LINE_COUNT: line_count_q <= pwdata[sset_pkg::LCNT_W-1:0];
        sset_pkg::REG_MAX_X:      max_x_q      <= pwdata[sset_pkg::MAXX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      sset_pkg::REG_LINE_COUNT: prdata = sset_pkg::DATA_W'(line_count_q);
      sset_pkg::REG_MAX_X:      prdata = sset_pkg::DATA_W'(max_x_q);
      default:                  prdata = '0;
    endcase
  end

  assign attr = {attr3_i, attr2_i, attr1_i, attr0_i};

  sset_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sset_dp #(
    .LINES (LINES),
    .ATTRS (ATTRS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .line_count_i (line_count_q),
    .max_x_i      (max_x_q),
    .action_i     (action_i),
    .line_i       (line_i),
    .x_i          (x_i),
    .attr_i       (attr),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .drawn_o      (drawn_o),
    .span_line_o  (span_line_o),
    .left_x_o     (left_x_o),
    .right_x_o    (right_x_o),
    .left_a_o     (left_a),
    .right_a_o    (right_a)
  );

  assign left_a0_o  = left_a[0];
  assign left_a1_o  = left_a[1];
  assign left_a2_o  = left_a[2];
  assign left_a3_o  = left_a[3];
  assign right_a0_o = right_a[0];
  assign right_a1_o = right_a[1];
  assign right_a2_o = right_a[2];
  assign right_a3_o = right_a[3];

endmodule
